// File: src/bsp_pkg.sv
// Shared types and constants for the breadth-first shortest-path engine.
// No dependencies; the top level, controller and datapath import this package.
package bsp_pkg;

    localparam int unsigned VTX_W = 6;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_PATH    = 3'd0,
        ST_NOPATH  = 3'd1,
        ST_INVALID = 3'd2,
        ST_ADDED   = 3'd3,
        ST_FULL    = 3'd4,
        ST_CLEARED = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_ADD_A, S_ADD_BRD, S_ADD_B, S_EMIT,
        S_DEQ, S_DEQW, S_HEAD, S_EDGE,
        S_PSTART, S_PWALK, S_POP, S_POUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    latch_in;
        logic    do_clear;
        logic    rd_head_a;
        logic    rd_head_b;
        logic    push_a;
        logic    push_b;
        logic    srch_init;
        logic    deq_rd;
        logic    deq_take;
        logic    head_take;
        logic    edge_step;
        logic    path_start;
        logic    path_walk;
        logic    pop_rd;
        logic    out_path;
        logic    out_single;
        logic    set_code;
        t_status code;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_action act;
        logic    bad_vtx;
        logic    pool_full;
        logic    cache_hit;
        logic    q_empty;
        logic    link_zero;
        logic    next_zero;
        logic    tgt_unreached;
        logic    at_src;
        logic    stack_empty;
        logic    out_free;
    } t_sts;

endpackage

// File: src/bfs_shortest_path_engine.sv
// Breadth-first shortest-path engine: top level, ties controller to datapath.
// Depends on bsp_pkg, bsp_ctrl, bsp_dp (and bsp_ram through bsp_dp).
// One request at a time; ready again once the result is loaded.
// A query with a new source runs the search: each dequeued vertex has its list
// entries read (one pool RAM read each) until the queue is empty; then a parent
// walk from target to source fills the path stack, and the path vertices are
// emitted from the stack, held by output stall. Cached source skips the search.
// Synchronous active-low reset
// empties the graph, sets vertex_count to 64 and drops the cached source.
module bfs_shortest_path_engine #(
    parameter int unsigned MAX_VERTS = 64,
    parameter int unsigned MAX_EDGES = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_action,
    input  logic [bsp_pkg::VTX_W-1:0] i_vertex_a,
    input  logic [bsp_pkg::VTX_W-1:0] i_vertex_b,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [6:0]                i_cfg_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [2:0]                o_status,
    output logic [bsp_pkg::VTX_W-1:0] o_path_vertex,
    output logic [bsp_pkg::VTX_W-1:0] o_distance,
    output logic                      o_last
);
    import bsp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    bsp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    bsp_dp #(.MAX_VERTS(MAX_VERTS), .MAX_EDGES(MAX_EDGES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_action(i_action), .i_vertex_a(i_vertex_a), .i_vertex_b(i_vertex_b),
        .i_cfg_we(i_cfg_valid && o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_path_vertex(o_path_vertex), .o_distance(o_distance), .o_last(o_last)
    );
endmodule

// File: src/bsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/bsp_ctrl.sv
// Sequencing state machine for the shortest-path engine.
// Depends on bsp_pkg; drives bsp_dp through t_cmd and reads t_sts.
module bsp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bsp_pkg::t_sts i_sts,
    output bsp_pkg::t_cmd o_cmd
);
    import bsp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_valid) n_state = S_DEC;
            S_DEC: begin
                case (i_sts.act)
                    ACT_CLEAR: n_state = S_EMIT;
                    ACT_NONE:  n_state = S_IDLE;
                    ACT_ADD: begin
                        if (i_sts.bad_vtx || i_sts.pool_full) n_state = S_EMIT;
                        else n_state = S_ADD_A;
                    end
                    default: begin
                        if (i_sts.bad_vtx) n_state = S_EMIT;
                        else if (i_sts.cache_hit) n_state = S_PSTART;
                        else n_state = S_DEQ;
                    end
                endcase
            end
            S_ADD_A:   n_state = S_ADD_BRD;
            S_ADD_BRD: n_state = S_ADD_B;
            S_ADD_B:   n_state = S_EMIT;
            S_EMIT:    if (i_sts.out_free) n_state = S_IDLE;
            S_DEQ:     n_state = i_sts.q_empty ? S_PSTART : S_DEQW;
            S_DEQW:    n_state = S_HEAD;
            S_HEAD:    n_state = i_sts.link_zero ? S_DEQ : S_EDGE;
            S_EDGE:    if (i_sts.next_zero) n_state = S_DEQ;
            S_PSTART:  n_state = i_sts.tgt_unreached ? S_EMIT : S_PWALK;
            S_PWALK:   if (i_sts.at_src) n_state = S_POP;
            S_POP:     n_state = S_POUT;
            S_POUT: begin
                if (i_sts.out_free) n_state = i_sts.stack_empty ? S_IDLE : S_POP;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready        = 1'b1;
                o_cmd.latch_in = 1'b1;
            end
            S_DEC: begin
                o_cmd.rd_head_a = 1'b1;
                if (i_sts.act == ACT_CLEAR) begin
                    o_cmd.do_clear = 1'b1;
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_CLEARED;
                end else if (i_sts.act != ACT_NONE && i_sts.bad_vtx) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_INVALID;
                end else if (i_sts.act == ACT_ADD && i_sts.pool_full) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_FULL;
                end else if (i_sts.act == ACT_QUERY && !i_sts.cache_hit) begin
                    o_cmd.srch_init = 1'b1;
                end
            end
            S_ADD_A:   o_cmd.push_a = 1'b1;
            S_ADD_BRD: o_cmd.rd_head_b = 1'b1;
            S_ADD_B: begin
                o_cmd.push_b   = 1'b1;
                o_cmd.set_code = 1'b1;
                o_cmd.code     = ST_ADDED;
            end
            S_EMIT:    o_cmd.out_single = i_sts.out_free;
            S_DEQ:     o_cmd.deq_rd = !i_sts.q_empty;
            S_DEQW:    o_cmd.deq_take = 1'b1;
            S_HEAD:    o_cmd.head_take = 1'b1;
            S_EDGE:    o_cmd.edge_step = 1'b1;
            S_PSTART: begin
                o_cmd.path_start = 1'b1;
                if (i_sts.tgt_unreached) begin
                    o_cmd.set_code = 1'b1;
                    o_cmd.code     = ST_NOPATH;
                end
            end
            S_PWALK:   o_cmd.path_walk = 1'b1;
            S_POP:     o_cmd.pop_rd = 1'b1;
            S_POUT:    o_cmd.out_path = i_sts.out_free;
            default:   o_cmd = '0;
        endcase
    end

    property p_pout_load;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_POUT && i_sts.out_free) |-> o_cmd.out_path;
    endproperty
    a_pout_load: assert property (p_pout_load)
        else $error("path result not loaded while output free");

    property p_accept_decodes;
        @(posedge i_clk) disable iff (!i_rst_n) (i_valid && o_ready) |=> (r_state == S_DEC);
    endproperty
    a_accept_decodes: assert property (p_accept_decodes)
        else $error("accepted request did not enter decode");

    property p_edge_exit;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_EDGE && i_sts.next_zero) |=> (r_state == S_DEQ);
    endproperty
    a_edge_exit: assert property (p_edge_exit)
        else $error("edge walk did not return to dequeue at list end");

    property p_walk_pop;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_PWALK && i_sts.at_src) |=> (r_state == S_POP);
    endproperty
    a_walk_pop: assert property (p_walk_pop)
        else $error("parent walk did not stop at source");
endmodule

// File: src/bsp_dp.sv
// Datapath: graph storage, search queue, distance/parent table, path stack
// and output register. Depends on bsp_pkg and bsp_ram.
module bsp_dp #(
    parameter int unsigned MAX_VERTS = 64,
    parameter int unsigned MAX_EDGES = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bsp_pkg::t_cmd               i_cmd,
    output bsp_pkg::t_sts               o_sts,
    input  logic [1:0]                  i_action,
    input  logic [bsp_pkg::VTX_W-1:0]   i_vertex_a,
    input  logic [bsp_pkg::VTX_W-1:0]   i_vertex_b,
    input  logic                        i_cfg_we,
    input  logic [6:0]                  i_cfg_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0]                  o_status,
    output logic [bsp_pkg::VTX_W-1:0]   o_path_vertex,
    output logic [bsp_pkg::VTX_W-1:0]   o_distance,
    output logic                        o_last
);
    import bsp_pkg::*;

    localparam int unsigned POOL = 2 * MAX_EDGES;
    localparam int unsigned VAW  = $clog2(MAX_VERTS);
    localparam int unsigned EW   = $clog2(POOL);
    localparam int unsigned LW   = $clog2(POOL + 1);
    localparam int unsigned CW   = VAW + 1;
    localparam logic [6:0]    MAXV   = 7'(MAX_VERTS);
    localparam logic [LW-1:0] FULL_AT = LW'(POOL - 2);

    // request and configuration
    logic [1:0]       r_act;
    logic [VTX_W-1:0] r_a, r_b;
    logic [6:0]       r_vc;
    logic [6:0]       w_n;

    // graph
    logic [MAX_VERTS-1:0] r_head_vld;
    logic                 r_hv_q;
    logic [LW-1:0]        r_used;
    logic                 r_cvld;
    logic [VTX_W-1:0]     r_csrc;

    // search
    logic [MAX_VERTS-1:0] r_vis;
    logic [CW-1:0]        r_wr, r_rd;
    logic [VTX_W-1:0]     r_u, r_ud;

    // path
    logic [VTX_W-1:0]     r_cur, r_d;
    logic [CW-1:0]        r_len;
    t_status              r_code;

    // output register
    logic                 r_o_valid;
    logic [2:0]           r_o_status;
    logic [VTX_W-1:0]     r_o_pv, r_o_dist;
    logic                 r_o_last;

    // ram ports
    logic                 head_we, head_re;
    logic [VAW-1:0]       head_waddr, head_raddr;
    logic [LW-1:0]        head_wdata, head_rdata, w_link;
    logic                 pool_we, pool_re;
    logic [EW-1:0]        pool_waddr, pool_raddr;
    logic [VTX_W+LW-1:0]  pool_wdata, pool_rdata;
    logic [VTX_W-1:0]     w_nb;
    logic [LW-1:0]        w_next, w_rlink;
    logic                 vi_we, vi_re;
    logic [VAW-1:0]       vi_waddr, vi_raddr;
    logic [2*VTX_W-1:0]   vi_wdata, vi_rdata;
    logic                 q_we;
    logic [VAW-1:0]       q_waddr;
    logic [VTX_W-1:0]     q_wdata, q_rdata;
    logic                 st_we;
    logic [VTX_W-1:0]     st_rdata;
    logic                 w_take;
    logic                 w_out_free;

    assign w_n        = (r_vc > MAXV) ? MAXV : r_vc;
    assign w_link     = r_hv_q ? head_rdata : '0;
    assign w_nb       = pool_rdata[VTX_W+LW-1:LW];
    assign w_next     = pool_rdata[LW-1:0];
    assign w_take     = i_cmd.edge_step && ({1'b0, w_nb} < w_n)
                        && !r_vis[w_nb[VAW-1:0]];
    assign w_out_free = !r_o_valid || i_ready;

    // status
    always_comb begin
        o_sts.act           = t_action'(r_act);
        o_sts.bad_vtx       = ({1'b0, r_a} >= w_n) || ({1'b0, r_b} >= w_n);
        o_sts.pool_full     = r_used > FULL_AT;
        o_sts.cache_hit     = r_cvld && (r_csrc == r_a);
        o_sts.q_empty       = r_rd == r_wr;
        o_sts.link_zero     = w_link == '0;
        o_sts.next_zero     = w_next == '0;
        o_sts.tgt_unreached = !r_vis[r_b[VAW-1:0]];
        o_sts.at_src        = r_cur == r_csrc;
        o_sts.stack_empty   = r_len == '0;
        o_sts.out_free      = w_out_free;
    end

    // head list ram
    always_comb begin
        head_re    = i_cmd.rd_head_a || i_cmd.rd_head_b || i_cmd.deq_take;
        head_raddr = i_cmd.deq_take  ? q_rdata[VAW-1:0] :
                     i_cmd.rd_head_b ? r_b[VAW-1:0] : r_a[VAW-1:0];
        head_we    = i_cmd.push_a || i_cmd.push_b;
        head_waddr = i_cmd.push_b ? r_b[VAW-1:0] : r_a[VAW-1:0];
        head_wdata = r_used + 1'b1;
    end

    // edge pool ram: {neighbour, next link}
    always_comb begin
        pool_we    = i_cmd.push_a || i_cmd.push_b;
        pool_waddr = r_used[EW-1:0];
        pool_wdata = {(i_cmd.push_b ? r_a : r_b), w_link};
        pool_re    = i_cmd.head_take || i_cmd.edge_step;
        w_rlink    = (i_cmd.edge_step ? w_next : w_link) - 1'b1;
        pool_raddr = w_rlink[EW-1:0];
    end

    // vertex info ram: {distance, parent}
    always_comb begin
        vi_we    = i_cmd.srch_init || w_take;
        vi_waddr = i_cmd.srch_init ? r_a[VAW-1:0] : w_nb[VAW-1:0];
        vi_wdata = i_cmd.srch_init ? '0 : {r_ud + 1'b1, r_u};
        vi_re    = i_cmd.deq_take || i_cmd.path_start || i_cmd.path_walk;
        vi_raddr = i_cmd.deq_take   ? q_rdata[VAW-1:0] :
                   i_cmd.path_start ? r_b[VAW-1:0] : vi_rdata[VAW-1:0];
    end

    // frontier queue
    always_comb begin
        q_we    = i_cmd.srch_init || w_take;
        q_waddr = i_cmd.srch_init ? '0 : r_wr[VAW-1:0];
        q_wdata = i_cmd.srch_init ? r_a : w_nb;
    end

    assign st_we = i_cmd.path_walk;

    bsp_ram #(.WIDTH(LW), .DEPTH(MAX_VERTS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_re(head_re), .i_raddr(head_raddr), .o_rdata(head_rdata)
    );
    bsp_ram #(.WIDTH(VTX_W + LW), .DEPTH(POOL)) u_pool (
        .i_clk(i_clk), .i_we(pool_we), .i_waddr(pool_waddr), .i_wdata(pool_wdata),
        .i_re(pool_re), .i_raddr(pool_raddr), .o_rdata(pool_rdata)
    );
    bsp_ram #(.WIDTH(2 * VTX_W), .DEPTH(MAX_VERTS)) u_vinfo (
        .i_clk(i_clk), .i_we(vi_we), .i_waddr(vi_waddr), .i_wdata(vi_wdata),
        .i_re(vi_re), .i_raddr(vi_raddr), .o_rdata(vi_rdata)
    );
    bsp_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTS)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_re(i_cmd.deq_rd), .i_raddr(r_rd[VAW-1:0]), .o_rdata(q_rdata)
    );
    bsp_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTS)) u_stack (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(r_len[VAW-1:0]), .i_wdata(r_cur),
        .i_re(i_cmd.pop_rd), .i_raddr(VAW'(r_len - 1'b1)), .o_rdata(st_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_act <= i_action;
            r_a   <= i_vertex_a;
            r_b   <= i_vertex_b;
        end
        if (head_re) begin
            r_hv_q <= r_head_vld[head_raddr];
        end
        if (i_cmd.deq_take) begin
            r_u <= q_rdata;
        end
        if (i_cmd.head_take) begin
            r_ud <= vi_rdata[2*VTX_W-1:VTX_W];
        end
        if (i_cmd.path_start) begin
            r_cur <= r_b;
        end else if (i_cmd.path_walk) begin
            r_cur <= vi_rdata[VTX_W-1:0];
            if (r_len == '0) begin
                r_d <= vi_rdata[2*VTX_W-1:VTX_W];
            end
        end
        if (i_cmd.set_code) begin
            r_code <= i_cmd.code;
        end
        if (i_cmd.srch_init) begin
            r_csrc <= r_a;
        end
        if (i_cmd.out_single) begin
            r_o_status <= r_code;
            r_o_pv     <= '0;
            r_o_dist   <= '0;
            r_o_last   <= 1'b1;
        end else if (i_cmd.out_path) begin
            r_o_status <= ST_PATH;
            r_o_pv     <= st_rdata;
            r_o_dist   <= r_d;
            r_o_last   <= r_len == '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc       <= 7'd64;
            r_head_vld <= '0;
            r_used     <= '0;
            r_cvld     <= 1'b0;
            r_vis      <= '0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_len      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vc   <= i_cfg_data;
                r_cvld <= 1'b0;
            end
            if (i_cmd.do_clear) begin
                r_head_vld <= '0;
                r_used     <= '0;
                r_cvld     <= 1'b0;
            end
            if (head_we) begin
                r_head_vld[head_waddr] <= 1'b1;
                r_used                 <= r_used + 1'b1;
                r_cvld                 <= 1'b0;
            end
            if (i_cmd.srch_init) begin
                // only the source starts out visited
                r_vis  <= MAX_VERTS'(1) << r_a[VAW-1:0];
                r_wr   <= CW'(1);
                r_rd   <= '0;
                r_cvld <= 1'b1;
            end
            if (i_cmd.deq_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_take) begin
                r_vis[w_nb[VAW-1:0]] <= 1'b1;
                r_wr                 <= r_wr + 1'b1;
            end
            if (i_cmd.path_start) begin
                r_len <= '0;
            end else if (i_cmd.path_walk) begin
                r_len <= r_len + 1'b1;
            end else if (i_cmd.pop_rd) begin
                r_len <= r_len - 1'b1;
            end
            if (i_cmd.out_single || i_cmd.out_path) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_path_vertex = r_o_pv;
    assign o_distance    = r_o_dist;
    assign o_last        = r_o_last;

    property p_pool_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_used <= LW'(POOL);
    endproperty
    a_pool_bound: assert property (p_pool_bound)
        else $error("edge pool count beyond pool size");

    property p_queue_order;
        @(posedge i_clk) disable iff (!i_rst_n) r_rd <= r_wr;
    endproperty
    a_queue_order: assert property (p_queue_order)
        else $error("queue read pointer passed write pointer");

    property p_no_overwrite;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_o_valid && !i_ready) |-> !(i_cmd.out_single || i_cmd.out_path);
    endproperty
    a_no_overwrite: assert property (p_no_overwrite)
        else $error("pending result overwritten");
endmodule
